// ===== rtl/mke_pkg.sv =====
package mke_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned UnitW = 10;
  localparam int unsigned DurW = 13;
  localparam int unsigned PatW = 7;
  localparam int unsigned LenW = 3;
  localparam int unsigned StepW = 3;

  localparam logic [UnitW-1:0] UnitReset = UnitW'(60);
  localparam logic [CharW-1:0] CharSpace = 8'h20;

  typedef enum logic [2:0] {
    EL_DOT        = 3'd0,
    EL_DASH       = 3'd1,
    EL_GAP_IN     = 3'd2,
    EL_GAP_LETTER = 3'd3,
    EL_GAP_WORD   = 3'd4
  } element_e;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_MORE     = 2'd2
  } cond_e;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic             mark_sel;
    element_e         element;
    logic             last;
    logic             shift;
    cond_e            cond;
    logic [StepW-1:0] next;
    logic [StepW-1:0] alt;
  } ucode_t;

  typedef struct packed {
    logic accept;
    logic is_space;
    logic is_known;
    logic more;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic            known;
    logic [LenW-1:0] len;
    logic [PatW-1:0] pattern;
  } code_t;

  // The pattern is left aligned in reading order, a one bit is a dash.
  function automatic code_t code_lookup(input logic [CharW-1:0] ch);
    code_t c;
    c = '{known: 1'b1, len: '0, pattern: '0};
    case (ch)
      8'h41: begin c.len = 3'd2; c.pattern = 7'b0100000; end
      8'h42: begin c.len = 3'd4; c.pattern = 7'b1000000; end
      8'h43: begin c.len = 3'd4; c.pattern = 7'b1010000; end
      8'h44: begin c.len = 3'd3; c.pattern = 7'b1000000; end
      8'h45: begin c.len = 3'd1; c.pattern = 7'b0000000; end
      8'h46: begin c.len = 3'd4; c.pattern = 7'b0010000; end
      8'h47: begin c.len = 3'd3; c.pattern = 7'b1100000; end
      8'h48: begin c.len = 3'd4; c.pattern = 7'b0000000; end
      8'h49: begin c.len = 3'd2; c.pattern = 7'b0000000; end
      8'h4A: begin c.len = 3'd4; c.pattern = 7'b0111000; end
      8'h4B: begin c.len = 3'd3; c.pattern = 7'b1010000; end
      8'h4C: begin c.len = 3'd4; c.pattern = 7'b0100000; end
      8'h4D: begin c.len = 3'd2; c.pattern = 7'b1100000; end
      8'h4E: begin c.len = 3'd2; c.pattern = 7'b1000000; end
      8'h4F: begin c.len = 3'd3; c.pattern = 7'b1110000; end
      8'h50: begin c.len = 3'd4; c.pattern = 7'b0110000; end
      8'h51: begin c.len = 3'd4; c.pattern = 7'b1101000; end
      8'h52: begin c.len = 3'd3; c.pattern = 7'b0100000; end
      8'h53: begin c.len = 3'd3; c.pattern = 7'b0000000; end
      8'h54: begin c.len = 3'd1; c.pattern = 7'b1000000; end
      8'h55: begin c.len = 3'd3; c.pattern = 7'b0010000; end
      8'h56: begin c.len = 3'd4; c.pattern = 7'b0001000; end
      8'h57: begin c.len = 3'd3; c.pattern = 7'b0110000; end
      8'h58: begin c.len = 3'd4; c.pattern = 7'b1001000; end
      8'h59: begin c.len = 3'd4; c.pattern = 7'b1011000; end
      8'h5A: begin c.len = 3'd4; c.pattern = 7'b1100000; end
      8'h31: begin c.len = 3'd5; c.pattern = 7'b0111100; end
      8'h32: begin c.len = 3'd5; c.pattern = 7'b0011100; end
      8'h33: begin c.len = 3'd5; c.pattern = 7'b0001100; end
      8'h34: begin c.len = 3'd5; c.pattern = 7'b0000100; end
      8'h35: begin c.len = 3'd5; c.pattern = 7'b0000000; end
      8'h36: begin c.len = 3'd5; c.pattern = 7'b1000000; end
      8'h37: begin c.len = 3'd5; c.pattern = 7'b1100000; end
      8'h38: begin c.len = 3'd5; c.pattern = 7'b1110000; end
      8'h39: begin c.len = 3'd5; c.pattern = 7'b1111000; end
      8'h30: begin c.len = 3'd5; c.pattern = 7'b1111100; end
      8'h2E: begin c.len = 3'd6; c.pattern = 7'b0101010; end
      8'h2C: begin c.len = 3'd6; c.pattern = 7'b1100110; end
      8'h3F: begin c.len = 3'd6; c.pattern = 7'b0011000; end
      8'h21: begin c.len = 3'd6; c.pattern = 7'b1010110; end
      8'h2F: begin c.len = 3'd5; c.pattern = 7'b1001000; end
      8'h28: begin c.len = 3'd5; c.pattern = 7'b1011000; end
      8'h29: begin c.len = 3'd6; c.pattern = 7'b1011010; end
      8'h27: begin c.len = 3'd6; c.pattern = 7'b0111100; end
      8'h26: begin c.len = 3'd5; c.pattern = 7'b0100000; end
      8'h3A: begin c.len = 3'd6; c.pattern = 7'b1110000; end
      8'h3B: begin c.len = 3'd6; c.pattern = 7'b1010100; end
      8'h3D: begin c.len = 3'd5; c.pattern = 7'b1000100; end
      8'h2B: begin c.len = 3'd5; c.pattern = 7'b0101000; end
      8'h2D: begin c.len = 3'd6; c.pattern = 7'b1000010; end
      8'h5F: begin c.len = 3'd6; c.pattern = 7'b0011010; end
      8'h22: begin c.len = 3'd6; c.pattern = 7'b0100100; end
      8'h24: begin c.len = 3'd7; c.pattern = 7'b0001001; end
      8'h40: begin c.len = 3'd6; c.pattern = 7'b0110100; end
      default: begin c.known = 1'b0; end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mke_char_if.sv =====
interface mke_char_if;
  logic                         valid;
  logic                         ready;
  logic [mke_pkg::CharW-1:0]    character;

  modport source(output valid, output character, input ready);
  modport sink(input valid, input character, output ready);
endinterface

// ===== rtl/mke_elem_if.sv =====
interface mke_elem_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 element;
  logic                       tone_on;
  logic [mke_pkg::DurW-1:0]   duration_ms;
  logic                       last;

  modport source(output valid, output element, output tone_on, output duration_ms,
                 output last, input ready);
  modport sink(input valid, input element, input tone_on, input duration_ms,
               input last, output ready);
endinterface

// ===== rtl/mke_sequencer.sv =====
module mke_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mke_pkg::status_t status_i,
  output mke_pkg::ucode_t  ucode_o
);

  localparam logic [mke_pkg::StepW-1:0] StepIdle   = 3'd0;
  localparam logic [mke_pkg::StepW-1:0] StepMark   = 3'd1;
  localparam logic [mke_pkg::StepW-1:0] StepGap    = 3'd2;
  localparam logic [mke_pkg::StepW-1:0] StepLetter = 3'd3;
  localparam logic [mke_pkg::StepW-1:0] StepWord   = 3'd4;
  localparam int unsigned ProgDepth = 2 ** mke_pkg::StepW;

  localparam mke_pkg::ucode_t UcIdle = '{
    load: 1'b1, emit: 1'b0, mark_sel: 1'b0, element: mke_pkg::EL_DOT, last: 1'b0,
    shift: 1'b0, cond: mke_pkg::COND_DISPATCH, next: StepIdle, alt: StepIdle};
  localparam mke_pkg::ucode_t UcMark = '{
    load: 1'b0, emit: 1'b1, mark_sel: 1'b1, element: mke_pkg::EL_DOT, last: 1'b0,
    shift: 1'b1, cond: mke_pkg::COND_MORE, next: StepGap, alt: StepLetter};
  localparam mke_pkg::ucode_t UcGap = '{
    load: 1'b0, emit: 1'b1, mark_sel: 1'b0, element: mke_pkg::EL_GAP_IN, last: 1'b0,
    shift: 1'b0, cond: mke_pkg::COND_NONE, next: StepMark, alt: StepMark};
  localparam mke_pkg::ucode_t UcLetter = '{
    load: 1'b0, emit: 1'b1, mark_sel: 1'b0, element: mke_pkg::EL_GAP_LETTER,
    last: 1'b1, shift: 1'b0, cond: mke_pkg::COND_NONE, next: StepIdle, alt: StepIdle};
  localparam mke_pkg::ucode_t UcWord = '{
    load: 1'b0, emit: 1'b1, mark_sel: 1'b0, element: mke_pkg::EL_GAP_WORD,
    last: 1'b1, shift: 1'b0, cond: mke_pkg::COND_NONE, next: StepIdle, alt: StepIdle};
  localparam mke_pkg::ucode_t UcSpare = '{
    load: 1'b0, emit: 1'b0, mark_sel: 1'b0, element: mke_pkg::EL_DOT, last: 1'b0,
    shift: 1'b0, cond: mke_pkg::COND_NONE, next: StepIdle, alt: StepIdle};

  localparam mke_pkg::ucode_t Program [ProgDepth] = '{
    UcIdle, UcMark, UcGap, UcLetter, UcWord, UcSpare, UcSpare, UcSpare};

  logic [mke_pkg::StepW-1:0] step_q, step_d;
  mke_pkg::ucode_t           uc;
  logic                      advance;

  assign uc      = Program[step_q];
  assign ucode_o = uc;
  assign advance = !(uc.emit && !status_i.out_free);

  always_comb begin
    step_d = step_q;
    if (advance) begin
      case (uc.cond)
        mke_pkg::COND_NONE: begin
          step_d = uc.next;
        end
        mke_pkg::COND_DISPATCH: begin
          if (status_i.accept && status_i.is_space) begin
            step_d = StepWord;
          end else if (status_i.accept && status_i.is_known) begin
            step_d = StepMark;
          end else begin
            step_d = uc.next;
          end
        end
        mke_pkg::COND_MORE: begin
          step_d = status_i.more ? uc.next : uc.alt;
        end
        default: begin
          step_d = StepIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== rtl/mke_datapath.sv =====
module mke_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mke_pkg::UnitW-1:0] cfg_wdata_i,
  input  mke_pkg::ucode_t           ucode_i,
  output mke_pkg::status_t          status_o,
  mke_char_if.sink                  char_i,
  mke_elem_if.source                elem_o
);

  logic [mke_pkg::UnitW-1:0] unit_q;
  logic [mke_pkg::PatW-1:0]  pat_q;
  logic [mke_pkg::LenW-1:0]  cnt_q;
  logic                      out_valid_q;
  mke_pkg::element_e         elem_q;
  logic                      tone_q;
  logic [mke_pkg::DurW-1:0]  dur_q;
  logic                      last_q;

  mke_pkg::code_t            code;
  mke_pkg::element_e         elem_sel;
  logic [mke_pkg::DurW-1:0]  unit_x1, unit_x3, unit_x7, dur_sel;
  logic                      accept, out_free, fire;

  assign code     = mke_pkg::code_lookup(char_i.character);
  assign accept   = char_i.valid && ucode_i.load;
  assign out_free = !out_valid_q || elem_o.ready;
  assign fire     = ucode_i.emit && out_free;

  assign char_i.ready = ucode_i.load;

  assign status_o.accept   = accept;
  assign status_o.is_space = (char_i.character == mke_pkg::CharSpace);
  assign status_o.is_known = code.known;
  assign status_o.more     = (cnt_q > mke_pkg::LenW'(1));
  assign status_o.out_free = out_free;

  assign elem_sel = ucode_i.mark_sel
                  ? (pat_q[mke_pkg::PatW-1] ? mke_pkg::EL_DASH : mke_pkg::EL_DOT)
                  : ucode_i.element;

  assign unit_x1 = mke_pkg::DurW'(unit_q);
  assign unit_x3 = (unit_x1 << 1) + unit_x1;
  assign unit_x7 = (unit_x1 << 3) - unit_x1;

  always_comb begin
    case (elem_sel)
      mke_pkg::EL_DASH, mke_pkg::EL_GAP_LETTER: dur_sel = unit_x3;
      mke_pkg::EL_GAP_WORD:                     dur_sel = unit_x7;
      default:                                  dur_sel = unit_x1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q      <= mke_pkg::UnitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      out_valid_q <= fire || (out_valid_q && !elem_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pat_q <= code.pattern;
      cnt_q <= code.len;
    end else if (fire && ucode_i.shift) begin
      pat_q <= pat_q << 1;
      cnt_q <= cnt_q - mke_pkg::LenW'(1);
    end
    if (fire) begin
      elem_q <= elem_sel;
      tone_q <= (elem_sel == mke_pkg::EL_DOT) || (elem_sel == mke_pkg::EL_DASH);
      dur_q  <= dur_sel;
      last_q <= ucode_i.last;
    end
  end

  assign elem_o.valid       = out_valid_q;
  assign elem_o.element     = elem_q;
  assign elem_o.tone_on     = tone_q;
  assign elem_o.duration_ms = dur_q;
  assign elem_o.last        = last_q;

endmodule

// ===== rtl/morse_keyer_encoder.sv =====
// Requests are taken only in the idle step, which the sequencer reenters after each character,
// and the mark step registers the first element. Marks are keyed with a gap between them and
// a closing letter gap, a space keys a word gap and an unsupported character nothing. Every
// other step emits an element, and within a character one leaves per cycle when not stalled.
// Reset is asynchronous and active low; it returns the unit time to 60 ms and empties the output.
module morse_keyer_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mke_pkg::UnitW-1:0] cfg_wdata_i,
  mke_char_if.sink                  char_i,
  mke_elem_if.source                elem_o
);

  mke_pkg::ucode_t  ucode;
  mke_pkg::status_t status;

  mke_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ucode_o  (ucode)
  );

  mke_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ucode_i     (ucode),
    .status_o    (status),
    .char_i      (char_i),
    .elem_o      (elem_o)
  );

endmodule

// ===== rtl/mke_checker.sv =====
module mke_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      char_valid_i,
  input logic                      char_ready_i,
  input logic [mke_pkg::CharW-1:0] character_i,
  input logic                      elem_valid_i,
  input logic                      elem_ready_i,
  input logic [2:0]                element_i,
  input logic                      tone_on_i,
  input logic [mke_pkg::DurW-1:0]  duration_ms_i,
  input logic                      last_i
);

  // A stalled element request keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_i && !elem_ready_i |=> elem_valid_i && $stable(element_i)
      && $stable(tone_on_i) && $stable(duration_ms_i) && $stable(last_i))
    else $error("stalled element request changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_i |-> tone_on_i == (element_i == mke_pkg::EL_DOT
      || element_i == mke_pkg::EL_DASH))
    else $error("tone does not match element kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_valid_i |-> last_i == (element_i == mke_pkg::EL_GAP_LETTER
      || element_i == mke_pkg::EL_GAP_WORD))
    else $error("last flag does not match closing gap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_i && char_ready_i && character_i == mke_pkg::CharSpace |=> !char_ready_i)
    else $error("space request did not start a word gap");

endmodule

bind morse_keyer_encoder mke_checker u_mke_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .char_valid_i  (char_i.valid),
  .char_ready_i  (char_i.ready),
  .character_i   (char_i.character),
  .elem_valid_i  (elem_o.valid),
  .elem_ready_i  (elem_o.ready),
  .element_i     (elem_o.element),
  .tone_on_i     (elem_o.tone_on),
  .duration_ms_i (elem_o.duration_ms),
  .last_i        (elem_o.last)
);

// ===== sim/mke_checker.sv =====
module mke_tb_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mke_pkg::UnitW-1:0] cfg_wdata_i,
  mke_char_if                       char_mon,
  mke_elem_if                       elem_mon,
  output int unsigned               fail_count_o,
  output int unsigned               outstanding_o
);

  typedef struct packed {
    mke_pkg::element_e        element;
    logic                     tone_on;
    logic [mke_pkg::DurW-1:0] duration_ms;
    logic                     last;
  } key_elem_t;

  logic [mke_pkg::UnitW-1:0] unit_ms;
  key_elem_t                 keying_q[$];
  key_elem_t                 want;
  key_elem_t                 got;
  int unsigned               errors;

  function automatic string morse_pattern(input logic [mke_pkg::CharW-1:0] c);
    case (c)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      "0": return "-----";
      ".": return ".-.-.-";
      ",": return "--..--";
      "?": return "..--..";
      "!": return "-.-.--";
      "/": return "-..-.";
      "(": return "-.--.";
      ")": return "-.--.-";
      8'h27: return ".----.";
      "&": return ".-...";
      ":": return "---...";
      ";": return "-.-.-.";
      "=": return "-...-";
      "+": return ".-.-.";
      "-": return "-....-";
      "_": return "..--.-";
      8'h22: return ".-..-.";
      "$": return "...-..-";
      "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic key_elem_t keyed(input mke_pkg::element_e el, input logic tone,
                                      input int units, input logic fin);
    key_elem_t e;
    e.element     = el;
    e.tone_on     = tone;
    e.duration_ms = mke_pkg::DurW'(int'(unit_ms) * units);
    e.last        = fin;
    return e;
  endfunction

  function automatic void expect_character(input logic [mke_pkg::CharW-1:0] c);
    string pat;
    pat = morse_pattern(c);
    if (c == mke_pkg::CharSpace) begin
      keying_q.push_back(keyed(mke_pkg::EL_GAP_WORD, 1'b0, 7, 1'b1));
      return;
    end
    if (pat.len() == 0) begin
      return;
    end
    for (int i = 0; i < pat.len(); i++) begin
      if (i > 0) begin
        keying_q.push_back(keyed(mke_pkg::EL_GAP_IN, 1'b0, 1, 1'b0));
      end
      if (pat[i] == "-") begin
        keying_q.push_back(keyed(mke_pkg::EL_DASH, 1'b1, 3, 1'b0));
      end else begin
        keying_q.push_back(keyed(mke_pkg::EL_DOT, 1'b1, 1, 1'b0));
      end
    end
    keying_q.push_back(keyed(mke_pkg::EL_GAP_LETTER, 1'b0, 3, 1'b1));
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ms       <= mke_pkg::UnitReset;
      keying_q.delete();
      errors        = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (elem_mon.valid && elem_mon.ready) begin
        got.element     = mke_pkg::element_e'(elem_mon.element);
        got.tone_on     = elem_mon.tone_on;
        got.duration_ms = elem_mon.duration_ms;
        got.last        = elem_mon.last;
        if (keying_q.size() == 0) begin
          note_failure($sformatf("%0t: unexpected element %0d tone %0d dur %0d last %0d",
                                 $realtime, got.element, got.tone_on, got.duration_ms,
                                 got.last));
        end else begin
          want = keying_q.pop_front();
          if (got.element !== want.element || got.tone_on !== want.tone_on ||
              got.duration_ms !== want.duration_ms || got.last !== want.last) begin
            note_failure($sformatf({"%0t: element mismatch, expected %0d/%0d/%0d/%0d, ",
                                    "got %0d/%0d/%0d/%0d (element/tone/dur/last)"},
                                   $realtime, want.element, want.tone_on,
                                   want.duration_ms, want.last, got.element,
                                   got.tone_on, got.duration_ms, got.last));
          end
        end
      end
      if (char_mon.valid && char_mon.ready) begin
        expect_character(char_mon.character);
      end
      if (cfg_we_i) begin
        unit_ms <= cfg_wdata_i;
      end
      fail_count_o  <= errors;
      outstanding_o <= keying_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [mke_pkg::UnitW-1:0] cfg_wdata;
  int                        idle_pct;
  int                        stall_pct;
  int unsigned               fail_count;
  int unsigned               outstanding;
  string                     keyable;
  string                     directed_text;
  logic [mke_pkg::UnitW-1:0] phase_units[5];

  mke_char_if char_if ();
  mke_elem_if elem_if ();

  morse_keyer_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .char_i      (char_if),
    .elem_o      (elem_if)
  );

  mke_tb_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .char_mon      (char_if),
    .elem_mon      (elem_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    elem_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_char(input logic [mke_pkg::CharW-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.character <= c;
    do @(posedge clk_i); while (!char_if.ready);
  endtask

  task automatic send_random_text(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_char(keyable[$urandom_range(keyable.len() - 1)]);
      end else if (pick < 80) begin
        send_char(mke_pkg::CharSpace);
      end else begin
        send_char(mke_pkg::CharW'($urandom_range(255)));
      end
    end
  endtask

  // A character with no elements leaves nothing to wait for, so a short pause
  // lets the sequencer return to idle before the unit time changes.
  task automatic drain;
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_unit(input logic [mke_pkg::UnitW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    keyable       = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?!/()'&:;=+-_\"$@";
    directed_text = "ETAZ09$@'\"._()/5 az";
    phase_units   = '{10'd1, 10'd1000, 10'd1023, 10'd0,
                      mke_pkg::UnitW'($urandom_range(999, 2))};
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    char_if.valid     = 1'b0;
    char_if.character = '0;
    elem_if.ready     = 1'b0;
    idle_pct          = 0;
    stall_pct         = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < directed_text.len(); i++) begin
      send_char(directed_text[i]);
    end
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h1F);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_unit(phase_units[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      send_random_text(21);
      drain();
    end

    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
